/* design/dg_moment_limiter_cascade_assert.svh */
// ----------------------------------------------------------------------------
// dml assertion macros
// Shared assertion forms for the moment limiter cascade; each expects clk and
// rst_n to be in scope at the place of use.
// ----------------------------------------------------------------------------
`ifndef DG_MOMENT_LIMITER_CASCADE_ASSERT_SVH
`define DG_MOMENT_LIMITER_CASCADE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define DML_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DML_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dml_pkg.sv */
// ----------------------------------------------------------------------------
// dml_pkg
// Shared constants for the moment limiter cascade.
// ----------------------------------------------------------------------------
package dml_pkg;

    localparam int DEFAULT_DATA_WIDTH = 32;
    localparam int NUM_MOMENTS        = 4;
    localparam int SCALE_BITS         = 16;
    localparam int TOL_WIDTH          = 16;
    localparam int ORDER_WIDTH        = 3;
    localparam int TOP_WIDTH          = 2;

    // configuration register indexes
    localparam logic REG_ORDER     = 1'b0;
    localparam logic REG_TOLERANCE = 1'b1;

    // sqrt(2k-1)/sqrt(2k+1) for moments one to four, unsigned q0.16
    localparam logic [SCALE_BITS-1:0] SCALE_Q16 [NUM_MOMENTS] =
        '{16'd37837, 16'd50764, 16'd55388, 16'd57797};

endpackage

/* design/dml_moment_if.sv */
// ----------------------------------------------------------------------------
// dml_moment_if
// Input channel: one element-equation pair with moments and differences.
// ----------------------------------------------------------------------------
interface dml_moment_if #(
    parameter int DATA_WIDTH = dml_pkg::DEFAULT_DATA_WIDTH
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] moment_one;
    logic [DATA_WIDTH-1:0] moment_two;
    logic [DATA_WIDTH-1:0] moment_three;
    logic [DATA_WIDTH-1:0] moment_four;
    logic [DATA_WIDTH-1:0] right_diff_zero;
    logic [DATA_WIDTH-1:0] right_diff_one;
    logic [DATA_WIDTH-1:0] right_diff_two;
    logic [DATA_WIDTH-1:0] right_diff_three;
    logic [DATA_WIDTH-1:0] left_diff_zero;
    logic [DATA_WIDTH-1:0] left_diff_one;
    logic [DATA_WIDTH-1:0] left_diff_two;
    logic [DATA_WIDTH-1:0] left_diff_three;

    modport source (
        output valid, moment_one, moment_two, moment_three, moment_four,
               right_diff_zero, right_diff_one, right_diff_two, right_diff_three,
               left_diff_zero, left_diff_one, left_diff_two, left_diff_three,
        input  ready
    );

    modport sink (
        input  valid, moment_one, moment_two, moment_three, moment_four,
               right_diff_zero, right_diff_one, right_diff_two, right_diff_three,
               left_diff_zero, left_diff_one, left_diff_two, left_diff_three,
        output ready
    );
endinterface

/* design/dml_limited_if.sv */
// ----------------------------------------------------------------------------
// dml_limited_if
// Output channel: the four moments after limiting.
// ----------------------------------------------------------------------------
interface dml_limited_if #(
    parameter int DATA_WIDTH = dml_pkg::DEFAULT_DATA_WIDTH
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] limited_one;
    logic [DATA_WIDTH-1:0] limited_two;
    logic [DATA_WIDTH-1:0] limited_three;
    logic [DATA_WIDTH-1:0] limited_four;

    modport source (
        output valid, limited_one, limited_two, limited_three, limited_four,
        input  ready
    );

    modport sink (
        input  valid, limited_one, limited_two, limited_three, limited_four,
        output ready
    );
endinterface

/* design/dg_moment_limiter_cascade.sv */
// ----------------------------------------------------------------------------
// dg_moment_limiter_cascade
// Moment limiter cascade for one element-equation pair per beat.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the output is not stalled and returns one
// result beat per input beat, in order. An item passes three registers: the
// input capture, the scaled sign/magnitude stage after the constant
// multipliers, and the result register after the minmod and cascade logic.
// The pipeline closes bubbles, so input is taken whenever a stage ahead is
// free or moving.
// The order and tolerance registers are written through wr_en, wr_index and
// wr_data and must only change while no item is in flight; orders 0 and 1 act
// as 2 and orders 6 and 7 act as 5. Data is signed two's complement, the
// scale constants are q0.16 and results are rounded to nearest.
// ----------------------------------------------------------------------------
`include "dg_moment_limiter_cascade_assert.svh"

module dg_moment_limiter_cascade #(
    parameter int DATA_WIDTH = dml_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic                          wr_index,
    input  logic [dml_pkg::TOL_WIDTH-1:0] wr_data,
    dml_moment_if.sink                    moments,
    dml_limited_if.source                 limited
);

    localparam int N = dml_pkg::NUM_MOMENTS;

    logic [dml_pkg::TOP_WIDTH-1:0] top_reg;
    logic [dml_pkg::TOP_WIDTH-1:0] top_next;
    logic [dml_pkg::TOL_WIDTH-1:0] tol_reg;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic en1;
    logic en2;
    logic en3;

    logic [DATA_WIDTH-1:0] mom_reg [N];
    logic [DATA_WIDTH-1:0] rd_reg  [N];
    logic [DATA_WIDTH-1:0] ld_reg  [N];

    logic                  mom_neg [N];
    logic [DATA_WIDTH-1:0] mom_mag [N];
    logic                  rd_neg  [N];
    logic [DATA_WIDTH-1:0] rd_mag  [N];
    logic                  ld_neg  [N];
    logic [DATA_WIDTH-1:0] ld_mag  [N];

    logic [DATA_WIDTH-1:0] limited_reg [N];

    // order is kept as the index of the highest moment in use
    always_comb
    begin
        case (wr_data[dml_pkg::ORDER_WIDTH-1:0])
            3'd0, 3'd1, 3'd2: top_next = 2'd0;
            3'd3:             top_next = 2'd1;
            3'd4:             top_next = 2'd2;
            default:          top_next = 2'd3;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= 2'd3;
            tol_reg <= '0;
        end
        else if (wr_en)
        begin
            if (wr_index == dml_pkg::REG_ORDER)
                top_reg <= top_next;
            else if (wr_index == dml_pkg::REG_TOLERANCE)
                tol_reg <= wr_data;
        end
    end

    // stage enables: a stage loads when it is empty or its contents move on
    assign en3 = !v3_reg || limited.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign moments.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= moments.valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            mom_reg[0] <= moments.moment_one;
            mom_reg[1] <= moments.moment_two;
            mom_reg[2] <= moments.moment_three;
            mom_reg[3] <= moments.moment_four;
            rd_reg[0]  <= moments.right_diff_zero;
            rd_reg[1]  <= moments.right_diff_one;
            rd_reg[2]  <= moments.right_diff_two;
            rd_reg[3]  <= moments.right_diff_three;
            ld_reg[0]  <= moments.left_diff_zero;
            ld_reg[1]  <= moments.left_diff_one;
            ld_reg[2]  <= moments.left_diff_two;
            ld_reg[3]  <= moments.left_diff_three;
        end
    end

    dml_scale #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_scale (
        .clk     (clk),
        .load    (en2),
        .mom_raw (mom_reg),
        .rd_raw  (rd_reg),
        .ld_raw  (ld_reg),
        .mom_neg (mom_neg),
        .mom_mag (mom_mag),
        .rd_neg  (rd_neg),
        .rd_mag  (rd_mag),
        .ld_neg  (ld_neg),
        .ld_mag  (ld_mag)
    );

    dml_cascade #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_cascade (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (en3),
        .top_idx     (top_reg),
        .tol         (tol_reg),
        .mom_neg     (mom_neg),
        .mom_mag     (mom_mag),
        .rd_neg      (rd_neg),
        .rd_mag      (rd_mag),
        .ld_neg      (ld_neg),
        .ld_mag      (ld_mag),
        .limited_reg (limited_reg)
    );

    assign limited.valid         = v3_reg;
    assign limited.limited_one   = limited_reg[0];
    assign limited.limited_two   = limited_reg[1];
    assign limited.limited_three = limited_reg[2];
    assign limited.limited_four  = limited_reg[3];

    `DML_ASSERT_NOW(a_ready_when_slot_free, !v3_reg, moments.ready, "input stalled, slot free")
    `DML_ASSERT_NEXT(a_no_extra, v3_reg && limited.ready && !v2_reg, !v3_reg, "extra result beat")
    `DML_ASSERT_NEXT(a_stage_two_fills, v1_reg && en2, v2_reg, "item lost before scale stage")

endmodule

/* design/dml_scale.sv */
// ----------------------------------------------------------------------------
// dml_scale
// Splits moments and differences into sign and magnitude and scales the
// difference magnitudes by the per-moment constant, rounded to nearest.
// ----------------------------------------------------------------------------
module dml_scale #(
    parameter int DATA_WIDTH = dml_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                  clk,
    input  logic                  load,
    input  logic [DATA_WIDTH-1:0] mom_raw  [dml_pkg::NUM_MOMENTS],
    input  logic [DATA_WIDTH-1:0] rd_raw   [dml_pkg::NUM_MOMENTS],
    input  logic [DATA_WIDTH-1:0] ld_raw   [dml_pkg::NUM_MOMENTS],
    output logic                  mom_neg  [dml_pkg::NUM_MOMENTS],
    output logic [DATA_WIDTH-1:0] mom_mag  [dml_pkg::NUM_MOMENTS],
    output logic                  rd_neg   [dml_pkg::NUM_MOMENTS],
    output logic [DATA_WIDTH-1:0] rd_mag   [dml_pkg::NUM_MOMENTS],
    output logic                  ld_neg   [dml_pkg::NUM_MOMENTS],
    output logic [DATA_WIDTH-1:0] ld_mag   [dml_pkg::NUM_MOMENTS]
);

    localparam int PROD_WIDTH = DATA_WIDTH + dml_pkg::SCALE_BITS;
    localparam logic [PROD_WIDTH-1:0] ROUND_HALF =
        PROD_WIDTH'(1) << (dml_pkg::SCALE_BITS - 1);

    logic [DATA_WIDTH-1:0] mom_mag_next [dml_pkg::NUM_MOMENTS];
    logic [DATA_WIDTH-1:0] rd_abs       [dml_pkg::NUM_MOMENTS];
    logic [DATA_WIDTH-1:0] ld_abs       [dml_pkg::NUM_MOMENTS];
    logic [PROD_WIDTH-1:0] rd_prod      [dml_pkg::NUM_MOMENTS];
    logic [PROD_WIDTH-1:0] ld_prod      [dml_pkg::NUM_MOMENTS];

    // magnitude of the most negative value still fits unsigned in the word
    always_comb
    begin
        for (int k = 0; k < dml_pkg::NUM_MOMENTS; k++)
        begin
            mom_mag_next[k] = mom_raw[k][DATA_WIDTH-1] ? -mom_raw[k] : mom_raw[k];
            rd_abs[k]       = rd_raw[k][DATA_WIDTH-1] ? -rd_raw[k] : rd_raw[k];
            ld_abs[k]       = ld_raw[k][DATA_WIDTH-1] ? -ld_raw[k] : ld_raw[k];
            rd_prod[k]      = PROD_WIDTH'(rd_abs[k]) * PROD_WIDTH'(dml_pkg::SCALE_Q16[k])
                              + ROUND_HALF;
            ld_prod[k]      = PROD_WIDTH'(ld_abs[k]) * PROD_WIDTH'(dml_pkg::SCALE_Q16[k])
                              + ROUND_HALF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < dml_pkg::NUM_MOMENTS; k++)
            begin
                mom_neg[k] <= mom_raw[k][DATA_WIDTH-1];
                mom_mag[k] <= mom_mag_next[k];
                rd_neg[k]  <= rd_raw[k][DATA_WIDTH-1];
                rd_mag[k]  <= rd_prod[k][PROD_WIDTH-1:dml_pkg::SCALE_BITS];
                ld_neg[k]  <= ld_raw[k][DATA_WIDTH-1];
                ld_mag[k]  <= ld_prod[k][PROD_WIDTH-1:dml_pkg::SCALE_BITS];
            end
        end
    end

endmodule

/* design/dml_cascade.sv */
// ----------------------------------------------------------------------------
// dml_cascade
// Minmod limiting of each moment and the top-down cascade that decides which
// limited values are kept; drives the result register.
// ----------------------------------------------------------------------------
`include "dg_moment_limiter_cascade_assert.svh"

module dml_cascade #(
    parameter int DATA_WIDTH = dml_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic [dml_pkg::TOP_WIDTH-1:0]  top_idx,
    input  logic [dml_pkg::TOL_WIDTH-1:0]  tol,
    input  logic                           mom_neg [dml_pkg::NUM_MOMENTS],
    input  logic [DATA_WIDTH-1:0]          mom_mag [dml_pkg::NUM_MOMENTS],
    input  logic                           rd_neg  [dml_pkg::NUM_MOMENTS],
    input  logic [DATA_WIDTH-1:0]          rd_mag  [dml_pkg::NUM_MOMENTS],
    input  logic                           ld_neg  [dml_pkg::NUM_MOMENTS],
    input  logic [DATA_WIDTH-1:0]          ld_mag  [dml_pkg::NUM_MOMENTS],
    output logic [DATA_WIDTH-1:0]          limited_reg [dml_pkg::NUM_MOMENTS]
);

    logic [DATA_WIDTH-1:0] tol_ext;
    logic [DATA_WIDTH-1:0] min_mag      [dml_pkg::NUM_MOMENTS];
    logic [DATA_WIDTH-1:0] lim_mag      [dml_pkg::NUM_MOMENTS];
    logic [DATA_WIDTH-1:0] change       [dml_pkg::NUM_MOMENTS];
    logic [DATA_WIDTH-1:0] sel_mag      [dml_pkg::NUM_MOMENTS];
    logic [DATA_WIDTH-1:0] limited_next [dml_pkg::NUM_MOMENTS];
    logic                  carry_on     [dml_pkg::NUM_MOMENTS];
    logic                  active       [dml_pkg::NUM_MOMENTS];

    assign tol_ext = DATA_WIDTH'(tol);

    always_comb
    begin
        for (int k = 0; k < dml_pkg::NUM_MOMENTS; k++)
        begin
            min_mag[k] = mom_mag[k];
            if (rd_mag[k] < min_mag[k])
                min_mag[k] = rd_mag[k];
            if (ld_mag[k] < min_mag[k])
                min_mag[k] = ld_mag[k];
            // zero unless all three are nonzero and agree in sign
            if (mom_mag[k] != '0 && rd_mag[k] != '0 && ld_mag[k] != '0 &&
                rd_neg[k] == mom_neg[k] && ld_neg[k] == mom_neg[k])
                lim_mag[k] = min_mag[k];
            else
                lim_mag[k] = '0;
            change[k]   = mom_mag[k] - lim_mag[k];
            carry_on[k] = (change[k] > tol_ext) || (lim_mag[k] <= tol_ext);
        end

        // walk down from the top moment while each step passes the test
        for (int k = dml_pkg::NUM_MOMENTS - 1; k >= 0; k--)
        begin
            if (k == dml_pkg::NUM_MOMENTS - 1)
                active[k] = (top_idx == dml_pkg::TOP_WIDTH'(k));
            else
                active[k] = (top_idx == dml_pkg::TOP_WIDTH'(k)) ||
                            (active[k+1] && carry_on[k+1]);
        end

        for (int k = 0; k < dml_pkg::NUM_MOMENTS; k++)
        begin
            sel_mag[k] = active[k] ? lim_mag[k] : mom_mag[k];
            if (dml_pkg::TOP_WIDTH'(k) > top_idx)
                limited_next[k] = '0;
            else
                limited_next[k] = mom_neg[k] ? -sel_mag[k] : sel_mag[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            limited_reg <= limited_next;
        end
    end

    // moments above the order in use come out as zero
    `DML_ASSERT_NEXT(a_top_unused_zero, load && top_idx != 2'd3, limited_reg[3] == '0, "unused moment four not zero")
    `DML_ASSERT_NEXT(a_low_order_zero, load && top_idx == 2'd0, limited_reg[1] == '0 && limited_reg[2] == '0, "unused moments two and three not zero")

endmodule
